// ----- sv/swmf_pkg.sv -----
// shared types and constants of the sliding window median filter
`timescale 1ns / 1ps
`default_nettype none

package swmf_pkg;

  localparam int KernelDef   = 3;
  localparam int MaxWidthDef = 1024;
  localparam int MaxHeight   = 4096;

  localparam int PixW       = 8;
  localparam int RowW       = 12;
  localparam int ColOutW    = 10;
  localparam int CfgWidthW  = 11;
  localparam int CfgHeightW = 13;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 13;
  localparam int PosW       = 13;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            start_of_frame;
  } in_beat_t;

  typedef struct packed {
    logic [PixW-1:0]    median;
    logic [RowW-1:0]    out_row;
    logic [ColOutW-1:0] out_col;
    logic               end_of_frame;
  } out_beat_t;

  typedef struct packed {
    logic [RowW-1:0]    out_row;
    logic [ColOutW-1:0] out_col;
    logic               end_of_frame;
    logic               produce;
  } swmf_pos_t;

endpackage

`default_nettype wire

// ----- sv/swmf_median.sv -----
// rank based median selection over one window
`timescale 1ns / 1ps
`default_nettype none

module swmf_median
  import swmf_pkg::*;
#(
  parameter int TAPS = KernelDef * KernelDef
) (
  input  logic [TAPS-1:0][PixW-1:0] win_i,
  output logic [PixW-1:0]           median_o
);

  always_comb begin
    logic [TAPS-1:0] below;
    median_o = '0;
    below    = '0;
    for (int i = 0; i < TAPS; i++) begin
      for (int j = 0; j < TAPS; j++) begin
        below[j] = (win_i[j] < win_i[i]) || ((win_i[j] == win_i[i]) && (j < i));
      end
      if ($countones(below) == TAPS / 2) begin
        median_o = median_o | win_i[i];
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/sliding_window_median_filter.sv -----
// top level of the streaming sliding window median filter
`timescale 1ns / 1ps
`default_nettype none

// Takes one pixel beat per clock in raster order and gives the median of the KERNEL x KERNEL
// window for every interior position, with its centre row and column and an end of frame
// flag on the last one; border positions give no beat. Throughput is one pixel per clock
// while out_stall_i is low. The line store read is registered with the accepted pixel, the
// window shifts when that beat leaves the first stage and the median then enters the output
// register. Frame size comes from the two configuration registers, which the user must
// write only while the stream is idle; the block itself does not enforce this.

module sliding_window_median_filter
  import swmf_pkg::*;
#(
  parameter int KERNEL    = KernelDef,
  parameter int MAX_WIDTH = MaxWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_beat_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_beat_t           out_data_o
);

  localparam int Taps  = KERNEL * KERNEL;
  localparam int Half  = KERNEL / 2;
  localparam int Lines = KERNEL - 1;
  localparam int ColW  = $clog2(MAX_WIDTH);

  typedef logic [Lines-1:0][PixW-1:0] line_word_t;

  // configuration
  logic [CfgWidthW-1:0]  frame_width_q;
  logic [CfgHeightW-1:0] frame_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= CfgWidthW'(1024);
      frame_height_q <= CfgHeightW'(1024);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[CfgWidthW-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[CfgHeightW-1:0];
        default: ;
      endcase
    end
  end

  logic [PosW-1:0] eff_w, eff_h;

  always_comb begin
    if (frame_width_q == '0) begin
      eff_w = PosW'(1);
    end else if (PosW'(frame_width_q) > PosW'(MAX_WIDTH)) begin
      eff_w = PosW'(MAX_WIDTH);
    end else begin
      eff_w = PosW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      eff_h = PosW'(1);
    end else if (PosW'(frame_height_q) > PosW'(MaxHeight)) begin
      eff_h = PosW'(MaxHeight);
    end else begin
      eff_h = PosW'(frame_height_q);
    end
  end

  // handshake and stage control
  logic v1_q, v2_q, out_valid_q;
  logic in_acc, s1_adv, s2_adv, s3_load, s3_free, s2_free, s1_free;
  swmf_pos_t pos1_q, pos2_q;

  assign s3_free    = !out_valid_q || !out_stall_i;
  assign s2_adv     = v2_q && (!pos2_q.produce || s3_free);
  assign s2_free    = !v2_q || s2_adv;
  assign s1_adv     = v1_q && s2_free;
  assign s1_free    = !v1_q || s1_adv;
  assign in_stall_o = !s1_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign s3_load    = s2_adv && pos2_q.produce;

  // position counters
  logic [ColW-1:0] col_cnt_q, col_cnt_d;
  logic [RowW-1:0] row_cnt_q, row_cnt_d;
  logic [PosW-1:0] cur_c, cur_r, row_rel, col_rel;
  logic            cur_prod, cur_eof;

  always_comb begin
    cur_c = in_data_i.start_of_frame ? '0 : PosW'(col_cnt_q);
    cur_r = in_data_i.start_of_frame ? '0 : PosW'(row_cnt_q);
    if (cur_c >= eff_w) begin
      cur_c = '0;
      cur_r = (cur_r + PosW'(1) >= eff_h) ? '0 : cur_r + PosW'(1);
    end
    if (cur_r >= eff_h) begin
      cur_r = '0;
    end
    if (cur_c + PosW'(1) >= eff_w) begin
      col_cnt_d = '0;
      row_cnt_d = (cur_r + PosW'(1) >= eff_h) ? '0 : RowW'(cur_r + PosW'(1));
    end else begin
      col_cnt_d = ColW'(cur_c + PosW'(1));
      row_cnt_d = RowW'(cur_r);
    end
    cur_prod = (cur_r >= PosW'(KERNEL - 1)) && (cur_c >= PosW'(KERNEL - 1));
    cur_eof  = (cur_r + PosW'(1) == eff_h) && (cur_c + PosW'(1) == eff_w);
    row_rel  = cur_r - PosW'(Half);
    col_rel  = cur_c - PosW'(Half);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (in_acc) begin
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
    end
  end

  // line store with read bypass for back to back beats on one column
  line_word_t      line_mem [MAX_WIDTH];
  line_word_t      rd_q, fwd_q, rd_word, wr_word;
  logic            byp_q;
  logic [PixW-1:0] px1_q;
  logic [ColW-1:0] col1_q;

  assign rd_word = byp_q ? fwd_q : rd_q;

  always_comb begin
    wr_word = rd_word;
    for (int i = 0; i < Lines - 1; i++) begin
      wr_word[i] = rd_word[i+1];
    end
    wr_word[Lines-1] = px1_q;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= line_mem[ColW'(cur_c)];
    end
    if (s1_adv) begin
      line_mem[col1_q] <= wr_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      byp_q <= 1'b0;
    end else begin
      if (in_acc) begin
        v1_q  <= 1'b1;
        byp_q <= v1_q && (ColW'(cur_c) == col1_q);
      end else if (s1_adv) begin
        v1_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px1_q  <= in_data_i.pixel;
      col1_q <= ColW'(cur_c);
      fwd_q  <= wr_word;
      pos1_q <= '{out_row:      row_rel[RowW-1:0],
                  out_col:      col_rel[ColOutW-1:0],
                  end_of_frame: cur_eof,
                  produce:      cur_prod};
    end
  end

  // window shift
  logic [KERNEL-1:0][KERNEL-1:0][PixW-1:0] win_q, win_d;
  logic [KERNEL-1:0][PixW-1:0]             column;

  always_comb begin
    for (int r = 0; r < Lines; r++) begin
      column[r] = rd_word[r];
    end
    column[KERNEL-1] = px1_q;
    for (int r = 0; r < KERNEL; r++) begin
      for (int c = 0; c < KERNEL - 1; c++) begin
        win_d[r][c] = win_q[r][c+1];
      end
      win_d[r][KERNEL-1] = column[r];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      win_q  <= win_d;
      pos2_q <= pos1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= s1_adv || (v2_q && !s2_adv);
    end
  end

  // median and output register
  logic [Taps-1:0][PixW-1:0] win_flat;
  logic [PixW-1:0]           median;
  out_beat_t                 out_q;

  assign win_flat = win_q;

  swmf_median #(
    .TAPS(Taps)
  ) u_median (
    .win_i   (win_flat),
    .median_o(median)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s3_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_load) begin
      out_q <= '{median:       median,
                 out_row:      pos2_q.out_row,
                 out_col:      pos2_q.out_col,
                 end_of_frame: pos2_q.end_of_frame};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
